>>> sv/bcvf_pkg.sv
package bcvf_pkg;

   // Largest image side, in pixels, that the block accepts.
   localparam int unsigned MAX_IMAGE_SIDE = 16384;

   localparam int ROW_W       = 12;
   localparam int COL_W       = 12;
   localparam int WORD_W      = 64;
   localparam int SIDE_W      = 15;
   localparam int FMT_W       = 3;
   localparam int INDEX_W     = 25;
   localparam int CSR_INDEX_W = 2;

   // Blocks along one side: ceil(side / 4) for a side of SIDE_W bits.
   localparam int BLOCKS_W = SIDE_W - 1;
   localparam int PROD_W   = 2 * BLOCKS_W;

   // Stream payload widths, padded to whole bytes.
   localparam int REQ_TDATA_W = ((ROW_W + COL_W + WORD_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((INDEX_W + WORD_W + 7) / 8) * 8;

   typedef logic [FMT_W-1:0]       format_type;
   typedef logic [CSR_INDEX_W-1:0] csr_index_type;

   localparam format_type FMT_BC1 = 3'd0;
   localparam format_type FMT_BC2 = 3'd1;
   localparam format_type FMT_BC3 = 3'd2;
   localparam format_type FMT_BC4 = 3'd3;
   localparam format_type FMT_BC5 = 3'd4;

   localparam csr_index_type CSR_FORMAT_CODE  = 2'd0;
   localparam csr_index_type CSR_IMAGE_WIDTH  = 2'd1;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 2'd2;

   // Colour word: the four row bytes in the upper half are reversed.
   function automatic logic [WORD_W-1:0] flip_colour(input logic [WORD_W-1:0] w);
      return {w[39:32], w[47:40], w[55:48], w[63:56], w[31:0]};
   endfunction

   // Explicit alpha word: the four 16-bit rows are reversed.
   function automatic logic [WORD_W-1:0] flip_alpha(input logic [WORD_W-1:0] w);
      return {w[15:0], w[31:16], w[47:32], w[63:48]};
   endfunction

   // Interpolated word: both endpoint bytes stay, the two 24-bit index groups
   // trade places and each group has its 12-bit halves swapped.
   function automatic logic [WORD_W-1:0] flip_interp(input logic [WORD_W-1:0] w);
      return {w[27:16], w[39:28], w[51:40], w[63:52], w[15:0]};
   endfunction

endpackage

>>> sv/bc_texture_block_vertical_flip_core.sv
// Channel    | Direction | Handshake             | Payload
// -----------+-----------+-----------------------+-----------------------------------------
// req_       | in        | req_tvalid/req_tready | tdata: block_row, block_col, data_in
//            |           |                       | tuser: word_half
// rsp_       | out       | rsp_tvalid/rsp_tready | tdata: dest_word_index, data_out
//            |           |                       | tuser: bad_item
// csr_       | in        | csr_valid/csr_ready   | csr_index, csr_data (register write)
//
// Every input transfer produces exactly one output transfer, and one new item can be taken
// every cycle while the output side is not stalled.
// There are three register stages: block counts and checks, the
// row-times-width multiply, and the final index add that feeds the output register.
// Reset is synchronous and active high; it empties the pipeline and restores BC1, 4 x 4.
// A stall on rsp_tready holds each full stage in place, so nothing is dropped or repeated.
module bc_texture_block_vertical_flip_core (
   input  logic                                clock,
   input  logic                                reset,
   // Input stream.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from 0 up: block_row[11:0], block_col[11:0], data_in[63:0].
   input  logic [bcvf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // Bit 0: word_half.
   input  logic                                req_tuser,
   // Result stream.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from 0 up: dest_word_index[24:0], data_out[63:0], then zero padding.
   output logic [bcvf_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // Bit 0: bad_item.
   output logic                                rsp_tuser,
   // Register write port.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  bcvf_pkg::csr_index_type             csr_index,
   input  logic [bcvf_pkg::SIDE_W-1:0]         csr_data
);

   localparam int ROW_W    = bcvf_pkg::ROW_W;
   localparam int COL_W    = bcvf_pkg::COL_W;
   localparam int WORD_W   = bcvf_pkg::WORD_W;
   localparam int SIDE_W   = bcvf_pkg::SIDE_W;
   localparam int BLOCKS_W = bcvf_pkg::BLOCKS_W;
   localparam int PROD_W   = bcvf_pkg::PROD_W;
   localparam int INDEX_W  = bcvf_pkg::INDEX_W;
   localparam int SUM_W    = PROD_W + 1;
   localparam int PAD_W    = bcvf_pkg::RSP_TDATA_W - INDEX_W - WORD_W;

   // Configuration registers.
   bcvf_pkg::format_type format_code_ff;
   logic [SIDE_W-1:0]    image_width_ff;
   logic [SIDE_W-1:0]    image_height_ff;

   // Input field unpacking.
   logic [ROW_W-1:0]  req_row;
   logic [COL_W-1:0]  req_col;
   logic [WORD_W-1:0] req_data;

   // Stage 1: checks, block counts, destination row and the rewritten word.
   logic                s1_valid_ff;
   logic                s1_bad_ff,       s1_bad_in;
   logic [BLOCKS_W-1:0] s1_dest_row_ff,  s1_dest_row_in;
   logic [BLOCKS_W-1:0] s1_blocks_wide_ff, s1_blocks_wide_in;
   logic [COL_W-1:0]    s1_col_ff;
   logic                s1_half_ff;
   logic                s1_two_words_ff, s1_two_words_in;
   logic [WORD_W-1:0]   s1_data_ff,      s1_data_in;

   // Stage 2: row offset in blocks.
   logic                s2_valid_ff;
   logic                s2_bad_ff;
   logic [PROD_W-1:0]   s2_prod_ff,      s2_prod_in;
   logic [COL_W-1:0]    s2_col_ff;
   logic                s2_half_ff;
   logic                s2_two_words_ff;
   logic [WORD_W-1:0]   s2_data_ff;

   // Stage 3: output register.
   logic                              s3_valid_ff;
   logic [bcvf_pkg::RSP_TDATA_W-1:0]  s3_tdata_ff, s3_tdata_in;
   logic                              s3_bad_ff;

   // Stage enables: a stage loads when it is empty or its content moves on.
   logic en1, en2, en3;

   // Combinational helpers for stage 1.
   logic [SIDE_W:0]     width_plus;
   logic [SIDE_W:0]     height_plus;
   logic [BLOCKS_W-1:0] blocks_high;
   logic                side_too_large;
   logic [BLOCKS_W-1:0] row_ext;

   // Combinational helpers for stage 3.
   logic [SUM_W-1:0]   block_index;
   logic [SUM_W:0]     word_index;
   logic [INDEX_W-1:0] dest_index;

   assign req_row  = req_tdata[ROW_W-1:0];
   assign req_col  = req_tdata[ROW_W+COL_W-1:ROW_W];
   assign req_data = req_tdata[ROW_W+COL_W+WORD_W-1:ROW_W+COL_W];

   assign en3        = !s3_valid_ff || rsp_tready;
   assign en2        = !s2_valid_ff || en3;
   assign en1        = !s1_valid_ff || en2;
   assign req_tready = en1;
   assign csr_ready  = 1'b1;

   // Register writes; indexes past the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         format_code_ff  <= bcvf_pkg::FMT_BC1;
         image_width_ff  <= SIDE_W'(4);
         image_height_ff <= SIDE_W'(4);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            bcvf_pkg::CSR_FORMAT_CODE:  format_code_ff  <= csr_data[bcvf_pkg::FMT_W-1:0];
            bcvf_pkg::CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            bcvf_pkg::CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage 1 logic. Block counts round the pixel sides up to multiples of four.
   always_comb begin
      width_plus        = {1'b0, image_width_ff} + (SIDE_W+1)'(3);
      height_plus       = {1'b0, image_height_ff} + (SIDE_W+1)'(3);
      s1_blocks_wide_in = width_plus[SIDE_W:2];
      blocks_high       = height_plus[SIDE_W:2];
      row_ext           = BLOCKS_W'(req_row);
      side_too_large    = (32'(image_width_ff) > bcvf_pkg::MAX_IMAGE_SIDE) ||
                          (32'(image_height_ff) > bcvf_pkg::MAX_IMAGE_SIDE);
      s1_two_words_in   = (format_code_ff == bcvf_pkg::FMT_BC2) ||
                          (format_code_ff == bcvf_pkg::FMT_BC3) ||
                          (format_code_ff == bcvf_pkg::FMT_BC5);

      s1_bad_in = (image_height_ff == '0) || (format_code_ff > bcvf_pkg::FMT_BC5) ||
                  side_too_large || (row_ext >= blocks_high) ||
                  (BLOCKS_W'(req_col) >= s1_blocks_wide_in) ||
                  (req_tuser && !s1_two_words_in);

      // Rows are mirrored only once the image spans at least one full block.
      if (image_height_ff >= SIDE_W'(4)) begin
         s1_dest_row_in = blocks_high - BLOCKS_W'(1) - row_ext;
      end else begin
         s1_dest_row_in = row_ext;
      end

      // A single pixel row has nothing to mirror.
      if (image_height_ff == SIDE_W'(1)) begin
         s1_data_in = req_data;
      end else begin
         unique case (format_code_ff)
            bcvf_pkg::FMT_BC1: s1_data_in = bcvf_pkg::flip_colour(req_data);
            bcvf_pkg::FMT_BC2: s1_data_in = req_tuser ? bcvf_pkg::flip_colour(req_data)
                                                      : bcvf_pkg::flip_alpha(req_data);
            bcvf_pkg::FMT_BC3: s1_data_in = req_tuser ? bcvf_pkg::flip_colour(req_data)
                                                      : bcvf_pkg::flip_interp(req_data);
            default:           s1_data_in = bcvf_pkg::flip_interp(req_data);
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en1) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_bad_ff         <= s1_bad_in;
         s1_dest_row_ff    <= s1_dest_row_in;
         s1_blocks_wide_ff <= s1_blocks_wide_in;
         s1_col_ff         <= req_col;
         s1_half_ff        <= req_tuser;
         s1_two_words_ff   <= s1_two_words_in;
         s1_data_ff        <= s1_data_in;
      end
   end

   // Stage 2: destination row times blocks per row.
   assign s2_prod_in = s1_dest_row_ff * s1_blocks_wide_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_bad_ff       <= s1_bad_ff;
         s2_prod_ff      <= s2_prod_in;
         s2_col_ff       <= s1_col_ff;
         s2_half_ff      <= s1_half_ff;
         s2_two_words_ff <= s1_two_words_ff;
         s2_data_ff      <= s1_data_ff;
      end
   end

   // Stage 3: add the column, scale by words per block and add the half.
   // Rejected items carry zero payload.
   always_comb begin
      block_index = {1'b0, s2_prod_ff} + SUM_W'(s2_col_ff);
      if (s2_two_words_ff) begin
         word_index = {block_index, s2_half_ff};
      end else begin
         word_index = {1'b0, block_index};
      end
      dest_index = word_index[INDEX_W-1:0];
      if (s2_bad_ff) begin
         s3_tdata_in = '0;
      end else begin
         s3_tdata_in = {{PAD_W{1'b0}}, s2_data_ff, dest_index};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en3) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_tdata_ff <= s3_tdata_in;
         s3_bad_ff   <= s2_bad_ff;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_tdata_ff;
   assign rsp_tuser  = s3_bad_ff;

endmodule

>>> sv/bcvf_checker.sv
module bcvf_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [bcvf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tuser
);

   // Reset empties the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // An empty output register means every stage can move, so input is taken.
   assert property (@(posedge clock) disable iff (reset) !rsp_tvalid |-> req_tready)
      else $error("input stalled while output is empty");

   // With the output side open, an accepted item reaches the output.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("accepted item did not reach the output");

   // A rejected item carries a zero index and zero data.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == '0))
      else $error("rejected item with nonzero payload");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("stalled result changed");

endmodule

bind bc_texture_block_vertical_flip_core bcvf_checker u_bcvf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
